// File: rtl/wpts_pkg.sv
// ----------------------------------------------------------------------------
// wpts_pkg
// Types, codes and defaults shared by the wait/priority task scheduler.
// ----------------------------------------------------------------------------
package wpts_pkg;

    // Default ready-list depth
    localparam int DEF_MAX_TASKS = 4;

    // Operation codes
    localparam logic [1:0] OP_ADMIT = 2'd0;
    localparam logic [1:0] OP_SLEEP = 2'd1;
    localparam logic [1:0] OP_ALARM = 2'd2;
    localparam logic [1:0] OP_START = 2'd3;

    // Outcome codes
    localparam logic [1:0] OUT_ADMITTED   = 2'd0;
    localparam logic [1:0] OUT_DISPATCHED = 2'd1;
    localparam logic [1:0] OUT_IDLE       = 2'd2;
    localparam logic [1:0] OUT_REJECTED   = 2'd3;

    // Resume modes
    localparam logic [1:0] MODE_FRESH     = 2'd0;
    localparam logic [1:0] MODE_SLEPT     = 2'd1;
    localparam logic [1:0] MODE_INTERRUPT = 2'd2;

    // Input beat
    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  task_id;
        logic [3:0]  priority_req;
        logic [15:0] wait_len;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [1:0]  outcome;
        logic [7:0]  dispatched_id;
        logic [1:0]  resume_mode;
        logic        alarm_set;
        logic [15:0] alarm_delay;
    } t_out_beat;

    // One ready-list entry
    typedef struct packed {
        logic [7:0]  task_id;
        logic [3:0]  prio;
        logic [15:0] wait_ticks;
        logic [1:0]  mode;
    } t_slot;

    // Per-cell control, one action at most per cycle
    typedef struct packed {
        logic load;        // take the load entry
        logic sub;         // lower wait by the alarm delay
        logic take_right;  // take right neighbor (shift or swap)
        logic take_left;   // take left neighbor (swap)
    } t_cell_ctrl;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_SORT,
        ST_DECIDE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// File: rtl/wait_priority_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// wait_priority_task_scheduler_unit
// Ready-list task scheduler built as a row of entry cells and a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one command
//   beat: admit, sleep, alarm or start. Output channel (o_out_valid /
//   i_out_stall / o_out_data) returns exactly one result beat per command.
//   One command is processed at a time; o_in_stall is high while busy.
//   Path from acceptance to result register:
//     admit or reject : straight to the hand-off state
//     start / sleep   : ordering pass, head decision, alarm search
//     alarm           : as sleep, after a wait decrement pass
//   The next command is taken in the cycle after a result is loaded; a
//   command is not taken before the previous one is through.
//   The ordering pass is an odd-even exchange between neighboring cells,
//   one round per cycle, MAX_TASKS rounds; the alarm search after a
//   dispatch visits one entry per cycle.
//   The result register frees the input side: a new command is accepted
//   while a result still waits; if the receiver stalls, the next result
//   waits in the sequencer until the register is taken.
//   Reset (synchronous, active low) empties the list, clears the running
//   task and the pending alarm delay.
// ----------------------------------------------------------------------------
module wait_priority_task_scheduler_unit #(
    parameter int MAX_TASKS = wpts_pkg::DEF_MAX_TASKS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wpts_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wpts_pkg::t_out_beat o_out_data
);
    import wpts_pkg::*;

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam logic [CNT_W-1:0] FULL      = CNT_W'(MAX_TASKS);
    localparam logic [CNT_W-1:0] LAST_ROUND = CNT_W'(MAX_TASKS - 1);

    // Control registers
    t_state           r_state,     n_state;
    logic [CNT_W-1:0] r_count,     n_count;
    logic [CNT_W-1:0] r_round,     n_round;
    logic [CNT_W-1:0] r_idx,       n_idx;
    logic             r_run_valid, n_run_valid;
    logic [7:0]       r_run_id,    n_run_id;
    logic [3:0]       r_run_prio,  n_run_prio;
    logic [15:0]      r_pending,   n_pending;
    logic             r_out_valid, n_out_valid;
    // Payload registers
    t_out_beat        r_res,       n_res;
    t_out_beat        r_out,       n_out;

    // Cell row
    t_cell_ctrl       cell_ctrl [MAX_TASKS];
    t_slot            cell_slot [MAX_TASKS];
    logic [MAX_TASKS-1:0] gt_right;
    logic             append;
    t_slot            load_slot;
    logic             swap_pair [MAX_TASKS];
    logic             do_sub;
    logic             do_sort;
    logic             do_shift;
    logic             accept;
    logic             out_free;
    t_slot            scan_slot;

    assign accept    = i_in_valid && (r_state == ST_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign scan_slot = cell_slot[r_idx[IDX_W-1:0]];

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++) begin : g_cell
            wpts_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (cell_ctrl[g]),
                .i_load     (load_slot),
                .i_left     (cell_slot[(g == 0) ? 0 : g - 1]),
                .i_right    (cell_slot[(g == MAX_TASKS - 1) ? g : g + 1]),
                .i_delay    (r_pending),
                .o_slot     (cell_slot[g]),
                .o_gt_right (gt_right[g])
            );
        end
    endgenerate

    // Cell control: append, decrement, sort exchange, dispatch shift
    always_comb begin
        for (int i = 0; i < MAX_TASKS; i++) begin
            swap_pair[i] = do_sort && (i[0] == r_round[0]) &&
                           (CNT_W'(i + 1) < r_count) && gt_right[i];
        end
        for (int i = 0; i < MAX_TASKS; i++) begin
            cell_ctrl[i].load       = append && (r_count[IDX_W-1:0] == IDX_W'(i));
            cell_ctrl[i].sub        = do_sub;
            cell_ctrl[i].take_right = do_shift || swap_pair[i];
            cell_ctrl[i].take_left  = (i > 0) ? swap_pair[(i > 0) ? i - 1 : 0] : 1'b0;
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_round     = r_round;
        n_idx       = r_idx;
        n_run_valid = r_run_valid;
        n_run_id    = r_run_id;
        n_run_prio  = r_run_prio;
        n_pending   = r_pending;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        append      = 1'b0;
        load_slot   = '{task_id: r_run_id, prio: r_run_prio,
                        wait_ticks: i_in_data.wait_len, mode: MODE_SLEPT};
        do_sub      = 1'b0;
        do_sort     = 1'b0;
        do_shift    = 1'b0;

        // Result register drains independently
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res   = '0;
                    n_round = '0;
                    unique case (i_in_data.operation)
                        OP_ADMIT: begin
                            load_slot = '{task_id: i_in_data.task_id,
                                          prio: i_in_data.priority_req,
                                          wait_ticks: i_in_data.wait_len,
                                          mode: MODE_FRESH};
                            if (r_count == FULL) begin
                                n_res.outcome = OUT_REJECTED;
                            end else begin
                                append  = 1'b1;
                                n_count = r_count + 1'b1;
                                n_res.outcome = OUT_ADMITTED;
                            end
                            n_state = ST_DONE;
                        end
                        OP_SLEEP: begin
                            if (!r_run_valid || r_count == FULL) begin
                                n_res.outcome = OUT_REJECTED;
                                n_state = ST_DONE;
                            end else begin
                                append      = 1'b1;
                                n_count     = r_count + 1'b1;
                                n_run_valid = 1'b0;
                                n_state     = ST_SORT;
                            end
                        end
                        OP_ALARM: begin
                            load_slot.wait_ticks = 16'd0;
                            load_slot.mode       = MODE_INTERRUPT;
                            if (r_run_valid && r_count == FULL) begin
                                n_res.outcome = OUT_REJECTED;
                                n_state = ST_DONE;
                            end else begin
                                if (r_run_valid) begin
                                    append      = 1'b1;
                                    n_count     = r_count + 1'b1;
                                    n_run_valid = 1'b0;
                                end
                                n_state = ST_SUB;
                            end
                        end
                        OP_START: begin
                            n_state = ST_SORT;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            // Lower every wait by the pending delay
            ST_SUB: begin
                do_sub    = 1'b1;
                n_pending = 16'd0;
                n_state   = ST_SORT;
            end
            // Odd-even exchange rounds
            ST_SORT: begin
                do_sort = 1'b1;
                n_round = r_round + 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_DECIDE;
                end
            end
            // Report idle when empty, else dispatch the head or program the head's wait
            ST_DECIDE: begin
                if (r_count == '0) begin
                    n_res.outcome = OUT_IDLE;
                    n_state = ST_DONE;
                end else if (cell_slot[0].wait_ticks != 16'd0) begin
                    n_res.outcome     = OUT_IDLE;
                    n_res.alarm_set   = 1'b1;
                    n_res.alarm_delay = cell_slot[0].wait_ticks;
                    n_pending         = cell_slot[0].wait_ticks;
                    n_state           = ST_DONE;
                end else begin
                    n_res.outcome       = OUT_DISPATCHED;
                    n_res.dispatched_id = cell_slot[0].task_id;
                    n_res.resume_mode   = cell_slot[0].mode;
                    n_run_valid         = 1'b1;
                    n_run_id            = cell_slot[0].task_id;
                    n_run_prio          = cell_slot[0].prio;
                    do_shift            = 1'b1;
                    n_count             = r_count - 1'b1;
                    n_idx               = '0;
                    n_state             = ST_SCAN;
                end
            end
            // First remaining entry more urgent than the dispatched task
            ST_SCAN: begin
                if (r_idx == r_count) begin
                    n_pending = 16'd0;
                    n_state   = ST_DONE;
                end else if (scan_slot.prio < r_run_prio) begin
                    n_res.alarm_set   = 1'b1;
                    n_res.alarm_delay = scan_slot.wait_ticks;
                    n_pending         = scan_slot.wait_ticks;
                    n_state           = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            // Hand the result to the output register
            ST_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_round     <= '0;
            r_idx       <= '0;
            r_run_valid <= 1'b0;
            r_run_id    <= 8'd0;
            r_run_prio  <= 4'd0;
            r_pending   <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_round     <= n_round;
            r_idx       <= n_idx;
            r_run_valid <= n_run_valid;
            r_run_id    <= n_run_id;
            r_run_prio  <= n_run_prio;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/wpts_cell.sv
// ----------------------------------------------------------------------------
// wpts_cell
// One ready-list entry: load, saturating wait decrement, neighbor exchange.
// ----------------------------------------------------------------------------
module wpts_cell (
    input  logic               i_clk,
    input  wpts_pkg::t_cell_ctrl i_ctrl,
    input  wpts_pkg::t_slot    i_load,
    input  wpts_pkg::t_slot    i_left,
    input  wpts_pkg::t_slot    i_right,
    input  logic [15:0]        i_delay,
    output wpts_pkg::t_slot    o_slot,
    output logic               o_gt_right
);
    import wpts_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    // Next entry value
    always_comb begin
        n_slot = r_slot;
        priority if (i_ctrl.load) begin
            n_slot = i_load;
        end else if (i_ctrl.sub) begin
            n_slot.wait_ticks = (r_slot.wait_ticks >= i_delay)
                              ? r_slot.wait_ticks - i_delay : 16'd0;
        end else if (i_ctrl.take_right) begin
            n_slot = i_right;
        end else if (i_ctrl.take_left) begin
            n_slot = i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    // Key (wait, priority) strictly above the right neighbor's
    assign o_gt_right = {r_slot.wait_ticks, r_slot.prio} >
                        {i_right.wait_ticks, i_right.prio};
    assign o_slot     = r_slot;

endmodule
